@@ design/bpfa_pkg.sv @@
// Package with shared types and constants of the page frame allocator.
package bpfa_pkg;

    typedef enum logic [2:0]
    {
        MODE_ALLOC      = 3'd0,
        MODE_FREE       = 3'd1,
        MODE_CONTIG     = 3'd2,
        MODE_MARK_FREE  = 3'd3,
        MODE_MARK_RSVD  = 3'd4
    } mode_t;

    localparam int unsigned COUNT_W   = 13;
    localparam int unsigned ADDR_W    = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

endpackage

@@ design/bitmap_page_frame_allocator.sv @@
// Top level of the first-fit bitmap page frame allocator.
//
// A request beat is taken at a rising edge where start is high and busy is
// low; mode, address, end_address and page_count are sampled then. The block
// raises busy and walks the bitmap one page at a time with a single shared
// compare and update path. The bitmap is a memory read at one address per
// cycle with registered read data, so every page visit takes a read state and
// an evaluation state. Contiguous allocation scans, then walks back over the
// found run to take its pages, and a free of one page visits at most that page.
// The result beat (page_address, found, free_pages) is shown for exactly one
// cycle with done high; the receiver cannot stall, so none is ever held.
// After reset the block first sweeps the bitmap to all ones, one word per
// cycle, with busy high; cfg_we writes
// total_pages at any time, and the free count resets to zero.
module bitmap_page_frame_allocator #(
    parameter int unsigned MAX_PAGES  = 4096,
    parameter int unsigned PAGE_SHIFT = 12,
    parameter int unsigned WORD_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bpfa_pkg::COUNT_W-1:0]  cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    mode,
    input  logic [bpfa_pkg::ADDR_W-1:0]   address,
    input  logic [bpfa_pkg::ADDR_W-1:0]   end_address,
    input  logic [bpfa_pkg::COUNT_W-1:0]  page_count,
    output logic                          done,
    output logic [bpfa_pkg::ADDR_W-1:0]   page_address,
    output logic                          found,
    output logic [bpfa_pkg::COUNT_W-1:0]  free_pages
);
    import bpfa_pkg::*;

    localparam int unsigned MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned BIT_W     = $clog2(WORD_BITS);
    localparam int unsigned PIDX_W    = WIDX_W + BIT_W;
    // Page indices wide enough to hold any page number and the page total.
    localparam int unsigned PG_W      = (PIDX_W > COUNT_W ? PIDX_W : COUNT_W) + 2;

    typedef enum logic [7:0]
    {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_READ  = 8'b0000_0100,
        ST_EVAL  = 8'b0000_1000,
        ST_TAKE  = 8'b0001_0000,
        ST_TREAD = 8'b0010_0000,
        ST_TEVAL = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_reg;

    state_t             state_reg, state_next;
    logic [PG_W-1:0]    idx_reg, idx_next;
    logic [PG_W-1:0]    last_reg, last_next;
    logic [PG_W-1:0]    span_base_reg, span_base_next;
    logic [COUNT_W-1:0] run_len_reg, run_len_next;
    logic [COUNT_W-1:0] want_reg, want_next;
    logic [2:0]         mode_reg, mode_next;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] free_reg, free_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic               hit_reg, hit_next;
    logic [WIDX_W-1:0]  clr_reg;

    logic               we;
    logic [WIDX_W-1:0]  wa;
    logic [WORD_BITS-1:0] wd;
    logic [WIDX_W-1:0]  ra;

    logic [PG_W-1:0]    lim;
    logic [PG_W-1:0]    first_pg, last_pg;
    logic [ADDR_W:0]    end_round;
    logic               bit_used;
    logic [BIT_W-1:0]   bsel;

    always_comb
    begin
        if ({{(PG_W-COUNT_W){1'b0}}, total_reg} > PG_W'(MAX_PAGES))
            lim = PG_W'(MAX_PAGES);
        else
            lim = {{(PG_W-COUNT_W){1'b0}}, total_reg};
    end

    assign end_round = {1'b0, end_address} + (ADDR_W+1)'((64'd1 << PAGE_SHIFT) - 64'd1);
    assign first_pg  = PG_W'(address >> PAGE_SHIFT);
    // The end page is clamped at full width so that a high end address cannot wrap.
    assign last_pg   = ((end_round >> PAGE_SHIFT) > (ADDR_W+1)'(lim))
                       ? lim : PG_W'(end_round >> PAGE_SHIFT);

    assign bsel     = idx_reg[BIT_W-1:0];
    assign bit_used = rd_reg[bsel];
    assign ra       = idx_reg[PIDX_W-1:BIT_W];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= COUNT_W'(4096);
        else if (cfg_we)
            total_reg <= cfg_wdata;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        span_base_next = span_base_reg;
        run_len_next   = run_len_reg;
        want_next      = want_reg;
        mode_next      = mode_reg;
        free_next      = free_reg;
        res_addr_next  = res_addr_reg;
        hit_next       = hit_reg;
        we             = 1'b0;
        wa             = ra;
        wd             = rd_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                wa = clr_reg;
                wd = '1;
                if (clr_reg == WIDX_W'(MAP_WORDS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next     = mode;
                    want_next     = page_count;
                    res_addr_next = '0;
                    hit_next      = 1'b0;
                    run_len_next  = '0;
                    span_base_next = '0;
                    state_next    = ST_READ;
                    case (mode)
                        MODE_ALLOC, MODE_CONTIG:
                        begin
                            idx_next  = '0;
                            last_next = lim;
                            if (mode == MODE_CONTIG && page_count == '0)
                                last_next = '0;
                        end
                        MODE_FREE:
                        begin
                            idx_next  = first_pg;
                            last_next = first_pg + PG_W'(1);
                            if (address[PAGE_SHIFT-1:0] != '0
                                || (address >> PAGE_SHIFT) >= ADDR_W'(lim))
                                last_next = first_pg;
                        end
                        MODE_MARK_FREE, MODE_MARK_RSVD:
                        begin
                            idx_next  = first_pg;
                            last_next = last_pg;
                            if ((address >> PAGE_SHIFT) >= ADDR_W'(lim))
                                last_next = '0;
                        end
                        default:
                        begin
                            last_next = '0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // The read issued here returns in the evaluation cycle.
                if (idx_reg >= last_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = ST_READ;
                idx_next   = idx_reg + PG_W'(1);
                case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (!bit_used)
                        begin
                            we = 1'b1;
                            wd = rd_reg | (WORD_BITS'(1) << bsel);
                            free_next = (free_reg != '0) ? free_reg - 1'b1 : free_reg;
                            res_addr_next = ADDR_W'(idx_reg) << PAGE_SHIFT;
                            hit_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                    end
                    MODE_FREE, MODE_MARK_FREE:
                    begin
                        if (bit_used)
                        begin
                            we = 1'b1;
                            wd = rd_reg & ~(WORD_BITS'(1) << bsel);
                            free_next = (free_reg != COUNT_MAX) ? free_reg + 1'b1 : free_reg;
                        end
                    end
                    MODE_MARK_RSVD:
                    begin
                        if (!bit_used)
                        begin
                            we = 1'b1;
                            wd = rd_reg | (WORD_BITS'(1) << bsel);
                            free_next = (free_reg != '0) ? free_reg - 1'b1 : free_reg;
                        end
                    end
                    MODE_CONTIG:
                    begin
                        if (bit_used)
                        begin
                            run_len_next   = '0;
                            span_base_next = idx_reg + PG_W'(1);
                        end
                        else if (run_len_reg + 1'b1 == want_reg)
                        begin
                            res_addr_next = ADDR_W'(span_base_reg) << PAGE_SHIFT;
                            hit_next   = 1'b1;
                            idx_next   = span_base_reg;
                            last_next  = idx_reg + PG_W'(1);
                            state_next = ST_TAKE;
                        end
                        else
                            run_len_next = run_len_reg + 1'b1;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_TAKE:
            begin
                if (idx_reg >= last_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_TEVAL;
            end
            ST_TEVAL:
            begin
                // Every page of the run was seen free, so each one is taken.
                we = 1'b1;
                wd = rd_reg | (WORD_BITS'(1) << bsel);
                free_next  = (free_reg != '0) ? free_reg - 1'b1 : free_reg;
                idx_next   = idx_reg + PG_W'(1);
                state_next = ST_TAKE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            free_reg  <= '0;
            idx_reg   <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_reg + 1'b1;
            free_reg  <= free_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        span_base_reg <= span_base_next;
        run_len_reg   <= run_len_next;
        want_reg      <= want_next;
        mode_reg      <= mode_next;
        res_addr_reg  <= res_addr_next;
        hit_reg       <= hit_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = (state_reg == ST_DONE);
    assign page_address = res_addr_reg;
    assign found        = hit_reg;
    assign free_pages   = free_reg;

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");
    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat lasted more than one cycle");
    a_miss_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (page_address == '0))
        else $error("failed allocation with non-zero address");
endmodule

@@ tb/bitmap_page_frame_allocator_tb.sv @@
// Self-checking testbench for the first-fit bitmap page frame allocator.
`timescale 1ns / 100ps

module bitmap_page_frame_allocator_tb;
    import bpfa_pkg::*;

    localparam int unsigned NUM_PAGES = 4096;
    localparam int unsigned PG_SHIFT  = 12;
    localparam longint CYCLE_LIMIT    = 6000000;
    localparam logic [2:0] MODE_BAD_5 = 3'd5;
    localparam logic [2:0] MODE_BAD_6 = 3'd6;
    localparam logic [2:0] MODE_BAD_7 = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0]  page_address;
        logic               found;
        logic [COUNT_W-1:0] free_pages;
    } alloc_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] mode = '0;
    logic [ADDR_W-1:0] address = '0;
    logic [ADDR_W-1:0] end_address = '0;
    logic [COUNT_W-1:0] page_count = '0;
    logic done;
    logic [ADDR_W-1:0] page_address;
    logic found;
    logic [COUNT_W-1:0] free_pages;

    bitmap_page_frame_allocator dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .mode(mode), .address(address),
        .end_address(end_address), .page_count(page_count), .done(done),
        .page_address(page_address), .found(found), .free_pages(free_pages)
    );

    always #5 clk = ~clk;

    // Shadow copy of the allocator state.
    bit page_used_map [NUM_PAGES];
    logic [COUNT_W-1:0] free_count_shadow;
    logic [COUNT_W-1:0] total_pages_shadow;

    alloc_result_t pending_results [$];
    int  error_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  allocs_found = 0;
    longint cycle_count = 0;
    int  burst_left = 0;

    function automatic int unsigned page_limit();
        return (total_pages_shadow > NUM_PAGES) ? NUM_PAGES : int'(total_pages_shadow);
    endfunction

    function automatic void claim_page(int unsigned idx);
        if (idx >= NUM_PAGES || page_used_map[idx])
            return;
        page_used_map[idx] = 1'b1;
        if (free_count_shadow != 0)
            free_count_shadow--;
    endfunction

    function automatic void release_page(int unsigned idx);
        if (idx >= NUM_PAGES || !page_used_map[idx])
            return;
        page_used_map[idx] = 1'b0;
        if (free_count_shadow != COUNT_MAX)
            free_count_shadow++;
    endfunction

    function automatic alloc_result_t predict_request(logic [2:0] m, logic [31:0] a,
                                                      logic [31:0] e, logic [12:0] n);
        alloc_result_t r;
        int unsigned lim;
        int unsigned span_base;
        int unsigned run_len;
        logic [32:0] end_round;
        longint unsigned first_pg;
        longint unsigned end_pg;
        lim = page_limit();
        r = '0;
        span_base = 0;
        run_len = 0;
        case (m)
            MODE_ALLOC:
                for (int unsigned i = 0; i < lim; i++)
                    if (!page_used_map[i])
                    begin
                        claim_page(i);
                        r.page_address = i << PG_SHIFT;
                        r.found = 1'b1;
                        break;
                    end
            MODE_FREE:
                if (a[PG_SHIFT-1:0] == '0 && (a >> PG_SHIFT) < lim)
                    release_page(a >> PG_SHIFT);
            MODE_CONTIG:
                if (n != 0)
                    for (int unsigned i = 0; i < lim; i++)
                    begin
                        if (page_used_map[i])
                        begin
                            run_len = 0;
                            span_base = i + 1;
                        end
                        else
                        begin
                            run_len++;
                            if (run_len == n)
                            begin
                                for (int unsigned j = span_base; j < span_base + n; j++)
                                    claim_page(j);
                                r.page_address = span_base << PG_SHIFT;
                                r.found = 1'b1;
                                break;
                            end
                        end
                    end
            MODE_MARK_FREE, MODE_MARK_RSVD:
            begin
                // The end is rounded up in 33 bits so it cannot wrap.
                end_round = {1'b0, e} + 33'd4095;
                first_pg = a >> PG_SHIFT;
                end_pg = end_round >> PG_SHIFT;
                if (end_pg > lim)
                    end_pg = lim;
                for (longint unsigned i = first_pg; i < end_pg; i++)
                    if (m == MODE_MARK_FREE)
                        release_page(i);
                    else
                        claim_page(i);
            end
            default: ;
        endcase
        r.free_pages = free_count_shadow;
        return r;
    endfunction

    // Sends one request beat; the request is accepted at the rising edge
    // after a falling edge that saw busy low.
    task automatic send_request(logic [2:0] m, logic [31:0] a, logic [31:0] e,
                                logic [12:0] n, bit use_gaps);
        int gap;
        if (use_gaps)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 30);
                @(negedge clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left--;
        end
        @(negedge clk);
        mode = m;
        address = a;
        end_address = e;
        page_count = n;
        start = 1'b1;
        while (busy)
            @(negedge clk);
        pending_results.push_back(predict_request(m, a, e, n));
        items_sent++;
        @(posedge clk);
    endtask

    task automatic stop_and_drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_total_pages(logic [12:0] value);
        stop_and_drain();
        cfg_we = 1'b1;
        cfg_wdata = value;
        total_pages_shadow = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        alloc_result_t exp_r;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with no request outstanding");
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (found)
                    allocs_found++;
                if (page_address !== exp_r.page_address)
                begin
                    $error("page_address expected %h actual %h", exp_r.page_address,
                           page_address);
                    error_count++;
                end
                if (found !== exp_r.found)
                begin
                    $error("found expected %0d actual %0d", exp_r.found, found);
                    error_count++;
                end
                if (free_pages !== exp_r.free_pages)
                begin
                    $error("free_pages expected %0d actual %0d", exp_r.free_pages,
                           free_pages);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_after_reset();
        // Every page is used after reset, so nothing can be allocated.
        send_request(MODE_ALLOC, 32'h0, 32'h0, 13'd0, 0);
        send_request(MODE_CONTIG, 32'h0, 32'h0, 13'd1, 0);
        send_request(MODE_FREE, 32'h0000_3000, 32'h0, 13'd0, 0);
    endtask

    task automatic test_full_map();
        send_request(MODE_MARK_FREE, 32'h0, 32'hFFFF_FFFF, 13'd0, 0);
        send_request(MODE_ALLOC, 32'h0, 32'h0, 13'd0, 0);
        send_request(MODE_CONTIG, 32'h0, 32'h0, 13'd4096, 0);
        send_request(MODE_FREE, 32'h0, 32'h0, 13'd0, 0);
        send_request(MODE_FREE, 32'h0, 32'h0, 13'd0, 0);
        send_request(MODE_CONTIG, 32'h0, 32'h0, 13'd4096, 0);
        send_request(MODE_ALLOC, 32'h0, 32'h0, 13'd0, 0);
        send_request(MODE_MARK_FREE, 32'h0000_5FFF, 32'h0000_9001, 13'd0, 0);
        send_request(MODE_FREE, 32'h0000_8001, 32'h0, 13'd0, 0);
        send_request(MODE_FREE, 32'h0100_0000, 32'h0, 13'd0, 0);
        send_request(MODE_MARK_RSVD, 32'h0000_9000, 32'h0000_6000, 13'd0, 0);
        send_request(MODE_CONTIG, 32'h0, 32'h0, 13'd0, 0);
        send_request(MODE_CONTIG, 32'h0, 32'h0, 13'd8191, 0);
        send_request(MODE_CONTIG, 32'h0, 32'h0, 13'd4, 0);
        send_request(MODE_BAD_5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'h1FFF, 0);
        send_request(MODE_BAD_6, 32'h0, 32'h0, 13'd0, 0);
        send_request(MODE_BAD_7, 32'h0000_6000, 32'h0000_9000, 13'd1, 0);
        send_request(MODE_MARK_RSVD, 32'h0, 32'hFFFF_FFFF, 13'd0, 0);
    endtask

    task automatic test_small_totals();
        write_total_pages(13'd0);
        send_request(MODE_MARK_FREE, 32'h0, 32'h0010_0000, 13'd0, 0);
        send_request(MODE_ALLOC, 32'h0, 32'h0, 13'd0, 0);
        write_total_pages(13'd1);
        send_request(MODE_MARK_FREE, 32'h0, 32'hFFFF_FFFF, 13'd0, 0);
        send_request(MODE_CONTIG, 32'h0, 32'h0, 13'd2, 0);
        send_request(MODE_ALLOC, 32'h0, 32'h0, 13'd0, 0);
        write_total_pages(13'd8191);
        send_request(MODE_FREE, 32'h00FF_F000, 32'h0, 13'd0, 0);
        send_request(MODE_ALLOC, 32'h0, 32'h0, 13'd0, 0);
    endtask

    // Random traffic, mostly well-formed requests within the managed pages.
    task automatic test_random_traffic(logic [12:0] total, int count);
        int unsigned lim;
        int unsigned sel;
        int unsigned pg;
        logic [2:0] m;
        logic [31:0] a;
        logic [31:0] e;
        logic [12:0] n;
        write_total_pages(total);
        lim = page_limit();
        for (int k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            pg = $urandom_range(0, lim + 2);
            a = pg << PG_SHIFT;
            e = (pg + $urandom_range(0, 10)) << PG_SHIFT;
            n = $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0)
                e = e | $urandom_range(0, 4095);
            if (sel < 30)
                m = MODE_ALLOC;
            else if (sel < 55)
            begin
                m = MODE_FREE;
                if ($urandom_range(0, 7) == 0)
                    a = a | $urandom_range(1, 4095);
            end
            else if (sel < 70)
                m = MODE_CONTIG;
            else if (sel < 83)
                m = MODE_MARK_FREE;
            else if (sel < 93)
                m = MODE_MARK_RSVD;
            else
            begin
                m = $urandom_range(0, 7);
                a = $urandom;
                e = $urandom;
                n = $urandom_range(0, 8191);
            end
            if (k == count / 2)
                stop_and_drain();
            send_request(m, a, e, n, k >= 40);
        end
    endtask

    initial
    begin
        total_pages_shadow = 13'd4096;
        free_count_shadow = '0;
        for (int i = 0; i < NUM_PAGES; i++)
            page_used_map[i] = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_full_map();
        test_small_totals();
        test_random_traffic(13'd64, 260);
        test_random_traffic(13'd37, 250);
        test_random_traffic(13'd100, 250);
        test_random_traffic(13'd1, 40);
        test_random_traffic(13'd33, 220);

        stop_and_drain();
        repeat (50) @(posedge clk);
        $display("Sent %0d requests and checked %0d results, %0d successful allocations.",
                 items_sent, results_seen, allocs_found);
        $display("Page totals covered: 0, 1, 33, 37, 64, 100, 4096 and the saturated 8191.");
        if (error_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/bpfa_pkg.sv
design/bitmap_page_frame_allocator.sv
tb/bitmap_page_frame_allocator_tb.sv
